// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising edge of clk.
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/kdlpr_pkg.sv =====
// Package: key count, event codes, register map and per-key state type.
package kdlpr_pkg;

    localparam int NUM_KEYS = 3;

    localparam int IN_BITS    = 32 + NUM_KEYS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 5 * NUM_KEYS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SHORT  = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_REPEAT   = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] LONG_RST     = 16'd1000;
    localparam logic [15:0] REPEAT_RST   = 16'd200;

    typedef struct packed {
        logic        level;
        logic [31:0] last_agree;
        logic [31:0] press_start;
        logic        long_fired;
        logic [31:0] last_repeat;
    } key_state_t;

    typedef logic [NUM_KEYS-1:0] key_vec_t;

endpackage

// ===== src/key_debounce_long_press_repeat_unit.sv =====
// Top level: key debouncer with short-press, long-press and auto-repeat events.
//
// Each input transaction carries a millisecond timestamp and the raw levels of
// all keys; each one yields exactly one output transaction with the debounced
// levels, the press and release edges and a two-bit event code per key. One
// input transaction can be taken every clock cycle while the output side is not
// stalled. The sample is held in an input register, every key is evaluated in
// parallel (three 32-bit subtract-and-compare paths per key) while the key state
// is updated, and the result sits in an output register until the output side
// takes it. Timing registers are written over the APB port at byte addresses
// 0, 4 and 8.
`include "assert_macros.svh"

module key_debounce_long_press_repeat_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kdlpr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_ms, raw_pressed, zero fill
    input  logic [kdlpr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pressed, press_edges, release_edges, events, zero fill
    output logic [kdlpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import kdlpr_pkg::*;

    // configuration
    logic [15:0] debounce_reg;
    logic [15:0] long_reg;
    logic [15:0] repeat_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // input stage
    logic        in_v_reg;
    logic [31:0] now_reg;
    key_vec_t    raw_reg;
    logic        advance;

    // key state
    key_state_t  key_reg  [NUM_KEYS];
    key_state_t  key_next [NUM_KEYS];

    // result
    logic        out_v_reg;
    key_vec_t    pressed_next, pedge_next, redge_next;
    logic [2*NUM_KEYS-1:0] events_next;
    key_vec_t    pressed_reg, pedge_reg, redge_reg;
    logic [2*NUM_KEYS-1:0] events_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            REG_LONG:     prdata = {16'd0, long_reg};
            REG_REPEAT:   prdata = {16'd0, repeat_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_reg     <= LONG_RST;
            repeat_reg   <= REPEAT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                REG_LONG:     long_reg     <= pwdata[15:0];
                REG_REPEAT:   repeat_reg   <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // the input register drains whenever the output register is free or emptying
    assign advance       = in_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_axis_tready)
            in_v_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            now_reg <= s_axis_tdata[31:0];
            raw_reg <= s_axis_tdata[32 +: NUM_KEYS];
        end
    end

    // per-key evaluation, all keys independent
    always_comb
    begin
        logic [31:0] since_agree;
        logic [31:0] since_press;
        logic [31:0] since_repeat;
        logic        long_hit;
        logic [1:0]  ev;

        pressed_next = '0;
        pedge_next   = '0;
        redge_next   = '0;
        events_next  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_next[k]  = key_reg[k];
            ev           = EV_NONE;
            since_agree  = now_reg - key_reg[k].last_agree;
            since_press  = now_reg - key_reg[k].press_start;
            since_repeat = now_reg - key_reg[k].last_repeat;
            long_hit     = 1'b0;

            if (raw_reg[k] != key_reg[k].level)
            begin
                if (since_agree >= {16'd0, debounce_reg})
                begin
                    key_next[k].level      = raw_reg[k];
                    key_next[k].last_agree = now_reg;
                    if (raw_reg[k])
                    begin
                        pedge_next[k]           = 1'b1;
                        key_next[k].press_start = now_reg;
                        key_next[k].long_fired  = 1'b0;
                        key_next[k].last_repeat = now_reg;
                    end
                    else
                    begin
                        redge_next[k] = 1'b1;
                        if (!key_reg[k].long_fired && since_press < {16'd0, long_reg})
                            ev = EV_SHORT;
                    end
                end
            end
            else
            begin
                key_next[k].last_agree = now_reg;
                if (key_reg[k].level)
                begin
                    long_hit = !key_reg[k].long_fired && since_press >= {16'd0, long_reg};
                    if (long_hit)
                    begin
                        key_next[k].long_fired  = 1'b1;
                        key_next[k].last_repeat = now_reg;
                        ev = EV_LONG;
                        // repeat time just reset to now: only a zero interval fires
                        if (repeat_reg == 16'd0)
                            ev = EV_REPEAT;
                    end
                    else if (key_reg[k].long_fired && since_repeat >= {16'd0, repeat_reg})
                    begin
                        key_next[k].last_repeat = now_reg;
                        ev = EV_REPEAT;
                    end
                end
            end

            pressed_next[k]       = key_next[k].level;
            events_next[2*k +: 2] = ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                key_reg[k] <= '0;
        end
        else if (advance)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                key_reg[k] <= key_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= 1'b1;
        else if (m_axis_tready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pressed_reg <= pressed_next;
            pedge_reg   <= pedge_next;
            redge_reg   <= redge_next;
            events_reg  <= events_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                            events_reg, redge_reg, pedge_reg, pressed_reg};

    `ASSERT_CLK(a_adv_fills_out, advance |=> m_axis_tvalid, "evaluated sample lost")
    `ASSERT_CLK(a_stall_only_on_out, (in_v_reg && !advance) |-> (out_v_reg && !m_axis_tready),
        "input stage stalled with output free")
    `ASSERT_NEVER(a_edge_level, m_axis_tvalid &&
        (((pedge_reg & ~pressed_reg) != '0) || ((redge_reg & pressed_reg) != '0)),
        "edge disagrees with debounced level")

endmodule

// ===== tb/tb_key_debounce_long_press_repeat_unit.sv =====
// Self-checking testbench for the key debouncer with long-press and auto-repeat events.
`timescale 1ns / 100ps

module tb_key_debounce_long_press_repeat_unit;

    import kdlpr_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 6;
    // index past the register map, writes to it must be dropped
    localparam logic [1:0]  REG_UNUSED = 2'd3;

    typedef struct {
        key_vec_t                pressed;
        key_vec_t                press_edges;
        key_vec_t                release_edges;
        logic [2*NUM_KEYS-1:0]   events;
    } key_report_t;

    class key_event_scoreboard;
        logic [15:0]  debounce_ms;
        logic [15:0]  long_press_ms;
        logic [15:0]  repeat_ms;
        key_state_t   keys [NUM_KEYS];
        key_report_t  pending_reports [$];
        int           errors;

        function new();
            debounce_ms   = DEBOUNCE_RST;
            long_press_ms = LONG_RST;
            repeat_ms     = REPEAT_RST;
            foreach (keys[k])
                keys[k] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_DEBOUNCE: debounce_ms   = value[15:0];
                REG_LONG:     long_press_ms = value[15:0];
                REG_REPEAT:   repeat_ms     = value[15:0];
                default:      ;
            endcase
        endfunction

        function logic [15:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_DEBOUNCE: return debounce_ms;
                REG_LONG:     return long_press_ms;
                REG_REPEAT:   return repeat_ms;
                default:      return 16'd0;
            endcase
        endfunction

        // Advance every key by one timestamped sample and queue the report it gives.
        function void note_sample(logic [31:0] now, key_vec_t raw);
            key_report_t  rep;
            logic [1:0]   ev;
            logic         lvl;
            rep.pressed       = '0;
            rep.press_edges   = '0;
            rep.release_edges = '0;
            rep.events        = '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                lvl = raw[k];
                ev  = EV_NONE;
                if (lvl != keys[k].level)
                begin
                    if (32'(now - keys[k].last_agree) >= debounce_ms)
                    begin
                        keys[k].level      = lvl;
                        keys[k].last_agree = now;
                        if (lvl)
                        begin
                            rep.press_edges[k]  = 1'b1;
                            keys[k].press_start = now;
                            keys[k].long_fired  = 1'b0;
                            keys[k].last_repeat = now;
                        end
                        else
                        begin
                            rep.release_edges[k] = 1'b1;
                            if (!keys[k].long_fired &&
                                32'(now - keys[k].press_start) < long_press_ms)
                                ev = EV_SHORT;
                        end
                    end
                end
                else
                begin
                    keys[k].last_agree = now;
                    if (keys[k].level)
                    begin
                        if (!keys[k].long_fired &&
                            32'(now - keys[k].press_start) >= long_press_ms)
                        begin
                            keys[k].long_fired  = 1'b1;
                            ev                  = EV_LONG;
                            keys[k].last_repeat = now;
                        end
                        // a repeat due in the same step replaces the long code
                        if (keys[k].long_fired &&
                            32'(now - keys[k].last_repeat) >= repeat_ms)
                        begin
                            ev                  = EV_REPEAT;
                            keys[k].last_repeat = now;
                        end
                    end
                end
                rep.pressed[k]       = keys[k].level;
                rep.events[2*k +: 2] = ev;
            end
            pending_reports.push_back(rep);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            key_report_t  want;
            key_report_t  got;
            if (pending_reports.size() == 0)
            begin
                $error("result %h with no sample outstanding", data);
                errors++;
                return;
            end
            want              = pending_reports.pop_front();
            got.pressed       = data[0 +: NUM_KEYS];
            got.press_edges   = data[NUM_KEYS +: NUM_KEYS];
            got.release_edges = data[2*NUM_KEYS +: NUM_KEYS];
            got.events        = data[3*NUM_KEYS +: 2*NUM_KEYS];
            if (got.pressed !== want.pressed)
            begin
                $error("pressed: expected %b, actual %b", want.pressed, got.pressed);
                errors++;
            end
            if (got.press_edges !== want.press_edges)
            begin
                $error("press_edges: expected %b, actual %b",
                       want.press_edges, got.press_edges);
                errors++;
            end
            if (got.release_edges !== want.release_edges)
            begin
                $error("release_edges: expected %b, actual %b",
                       want.release_edges, got.release_edges);
                errors++;
            end
            if (got.events !== want.events)
            begin
                $error("events: expected %b, actual %b", want.events, got.events);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]    paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // now_ms [31:0], raw_pressed, zero fill
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // pressed, press_edges, release_edges, events, zero fill
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    key_event_scoreboard  board = new();
    logic                 idle_en = 1'b1;
    logic [31:0]          clock_ms = '0;
    int                   stall_cycles = 0;
    string                reg_names [3] = '{"debounce_ms", "long_press_ms", "repeat_ms"};

    key_debounce_long_press_repeat_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // result side: back-pressure and checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= idle_en ? ($urandom_range(0, 99) >= 11) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [31:0] now, key_vec_t raw);
        logic [IN_TDATA_W-1:0] word;
        word               = '0;
        word[31:0]         = now;
        word[32 +: NUM_KEYS] = raw;
        while (idle_en && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(now, raw);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic [1:0] idx, logic write, logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (write)
            board.write_reg(idx, wdata);
        else if (prdata !== {16'd0, board.reg_value(idx)})
        begin
            $error("%s: expected %h, actual %h", reg_names[idx],
                   {16'd0, board.reg_value(idx)}, prdata);
            board.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all timing registers with junk in the upper half, then read them back.
    task automatic set_timing(logic [15:0] deb, logic [15:0] lng, logic [15:0] rpt);
        logic [15:0] junk;
        wait_drained();
        junk = 16'($urandom);
        apb_access(REG_DEBOUNCE, 1'b1, {junk, deb});
        junk = 16'($urandom);
        apb_access(REG_LONG, 1'b1, {junk, lng});
        junk = 16'($urandom);
        apb_access(REG_REPEAT, 1'b1, {junk, rpt});
        apb_access(REG_UNUSED, 1'b1, $urandom);
        apb_access(REG_DEBOUNCE, 1'b0, '0);
        apb_access(REG_LONG, 1'b0, '0);
        apb_access(REG_REPEAT, 1'b0, '0);
    endtask

    // Mostly held levels with bounce, time steps scaled to the current timing registers.
    task automatic run_random(int n, bit pause_midway);
        key_vec_t     target;
        key_vec_t     raw;
        int unsigned  step;
        int unsigned  sel;
        target = '0;
        for (int i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 25)
                step = $urandom_range(0, 3);
            else if (sel < 55)
                step = $urandom_range(0, board.debounce_ms + board.debounce_ms / 2 + 2);
            else if (sel < 80)
                step = $urandom_range(0, board.long_press_ms / 3 + 2);
            else if (sel < 97)
                step = $urandom_range(0, board.repeat_ms + 2);
            else
                step = $urandom;
            clock_ms = clock_ms + step;
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 99) < 10)
                    target[k] = ~target[k];
            raw = target;
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 99) < 15)
                    raw[k] = ~raw[k];
            if ($urandom_range(0, 99) < 5)
                raw = NUM_KEYS'($urandom);
            send_sample(clock_ms, raw);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: bounce, short, long, repeat, late releases, wrap of the ms counter
        send_sample(32'd0, 3'b000);
        send_sample(32'd10, 3'b001);
        send_sample(32'd60, 3'b000);
        send_sample(32'd100, 3'b001);
        send_sample(32'd120, 3'b001);
        send_sample(32'd300, 3'b000);
        send_sample(32'd400, 3'b010);
        send_sample(32'd1400, 3'b010);
        send_sample(32'd1500, 3'b010);
        send_sample(32'd1600, 3'b010);
        send_sample(32'd1700, 3'b000);
        send_sample(32'd1800, 3'b100);
        send_sample(32'd2900, 3'b000);
        send_sample(32'd3000, 3'b111);
        send_sample(32'd3050, 3'b000);
        send_sample(32'hFFFF_FFFF, 3'b111);
        send_sample(32'd16, 3'b111);
        send_sample(32'd1000, 3'b111);
        send_sample(32'd1000, 3'b111);
        send_sample(32'd1200, 3'b111);
        send_sample(32'd1210, 3'b000);
        clock_ms = 32'd1210;

        run_random(90, 1'b1);

        set_timing(16'd0, 16'd0, 16'd0);
        run_random(70, 1'b0);

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(60, 1'b0);

        set_timing(16'd5, 16'd100, 16'd20);
        clock_ms = 32'hFFFF_FF00;
        run_random(90, 1'b0);

        // no idling on either side for this stretch
        set_timing(16'd20, 16'd300, 16'd0);
        idle_en = 1'b0;
        run_random(90, 1'b0);
        idle_en = 1'b1;

        set_timing(16'($urandom_range(0, 120)), 16'($urandom_range(0, 1500)),
                   16'($urandom_range(0, 300)));
        run_random(100, 1'b0);

        wait_drained();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
